/* rtl/vtyp_pkg.sv */
// ----------------------------------------------------------------------------
// vtyp_pkg: shared types and constants for the vector to yaw/pitch block
// Holds the request and result structs, the octant sideband and the
// arctangent rounding edges used to build the first-octant ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package vtyp_pkg;

  localparam int unsigned FIELD_BITS = 24;
  localparam int unsigned ANGLE_BITS = 12;
  localparam int unsigned EDGE_COUNT = 32;

  // octant codes, 256 per turn
  localparam logic [7:0] OCT_DIAG  = 8'h20;
  localparam logic [7:0] OCT_QTR   = 8'h40;
  localparam logic [7:0] OCT_HALF  = 8'h80;
  // output base, 4096 per turn
  localparam logic [ANGLE_BITS-1:0] ANGLE_BASE = 12'h800;

  // quadrant codes (bit0: negated first leg not negative, bit1: negated second leg negative)
  localparam logic [1:0] QUAD_NN = 2'd0;
  localparam logic [1:0] QUAD_PN = 2'd1;
  localparam logic [1:0] QUAD_NP = 2'd2;
  localparam logic [1:0] QUAD_PP = 2'd3;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] vec_x;
    logic signed [FIELD_BITS-1:0] vec_y;
    logic signed [FIELD_BITS-1:0] vec_z;
  } req_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
  } res_t;

  // octant sideband that travels beside the divider
  typedef struct packed {
    logic       lt;    // first leg shorter than second
    logic       eq;    // legs equal
    logic [1:0] quad;
  } oct_t;

  // tan((k+0.5)*pi/128) scaled by 1e7
  localparam logic [31:0] ROUND_EDGES [EDGE_COUNT] = '{
    32'd122724,  32'd368321,  32'd614363,  32'd861148,
    32'd1108979, 32'd1358162, 32'd1609013, 32'd1861853,
    32'd2117031, 32'd2374837, 32'd2635236, 32'd2899948,
    32'd3167985, 32'd3440226, 32'd3717105, 32'd3999082,
    32'd4286649, 32'd4580336, 32'd4880702, 32'd5188352,
    32'd5503939, 32'd5828750, 32'd6161748, 32'd6505694,
    32'd6860772, 32'd7227993, 32'd7608482, 32'd8003455,
    32'd8414260, 32'd8842300, 32'd9289526, 32'd9757527
  };

  // ROM entry i of a table with steps entries: count the rounding edges passed
  function automatic logic [5:0] rom_entry(input longint unsigned idx,
                                           input longint unsigned steps);
    logic [5:0] v;
    v = '0;
    for (int k = 0; k < EDGE_COUNT; k++) begin
      if (idx * 64'd10000000 >= steps * 64'(ROUND_EDGES[k])) begin
        v = v + 6'd1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/vtyp_prep.sv */
// ----------------------------------------------------------------------------
// vtyp_prep: leg preparation
// Three register stages: absolute values, yaw legs with planar length,
// then pitch legs. Presents a numerator, denominator and octant per angle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtyp_prep #(
  parameter int unsigned W = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  vtyp_pkg::req_t       req_i,
  output logic                 valid_o,
  output logic [W:0]           yaw_num_o,
  output logic [W:0]           yaw_den_o,
  output vtyp_pkg::oct_t       yaw_oct_o,
  output logic [W:0]           pit_num_o,
  output logic [W:0]           pit_den_o,
  output vtyp_pkg::oct_t       pit_oct_o
);

  localparam int unsigned M = W + 1;

  logic [2:0] vld_q;

  // stage 1: magnitudes and signs
  logic signed [W-1:0] xs, ys, zs;
  logic [M-1:0] xe, ye, ze;
  logic [M-1:0] ax_d, ay_d, az_d;
  logic [M-1:0] ax_q, ay_q, az_q;
  logic         xp_q, yp_q, zp_q;

  assign xs = req_i.vec_x[W-1:0];
  assign ys = req_i.vec_y[W-1:0];
  assign zs = req_i.vec_z[W-1:0];
  assign xe = {xs[W-1], xs};
  assign ye = {ys[W-1], ys};
  assign ze = {zs[W-1], zs};
  assign ax_d = xs[W-1] ? (~xe + M'(1)) : xe;
  assign ay_d = ys[W-1] ? (~ye + M'(1)) : ye;
  assign az_d = zs[W-1] ? (~ze + M'(1)) : ze;

  // stage 2: yaw legs and planar length
  logic         ylt_d, yeq_d;
  logic [M-1:0] d_d;
  logic [M-1:0] ax3, az3;
  logic [M-1:0] ynum_q, yden_q, d_q, ay2_q;
  vtyp_pkg::oct_t yoct_q, yoct2_q;
  logic           yp2_q;
  logic [M-1:0]   ynum2_q, yden2_q;

  assign ylt_d = ax_q < az_q;
  assign yeq_d = ax_q == az_q;
  assign ax3 = (ax_q >> 3) + ((ax_q >> 3) << 1);
  assign az3 = (az_q >> 3) + ((az_q >> 3) << 1);
  assign d_d = (az_q < ax_q) ? (ax_q + az3) : (az_q + ax3);

  // stage 3: pitch legs
  logic plt_d, peq_d;
  logic [M-1:0] pnum_q, pden_q;
  vtyp_pkg::oct_t poct_q;

  assign plt_d = ay2_q < d_q;
  assign peq_d = ay2_q == d_q;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    az_q <= az_d;
    xp_q <= !xs[W-1] && (xs != '0);
    yp_q <= !ys[W-1] && (ys != '0);
    zp_q <= !zs[W-1] && (zs != '0);

    ynum_q       <= ylt_d ? ax_q : az_q;
    yden_q       <= ylt_d ? az_q : ax_q;
    yoct_q.lt    <= ylt_d;
    yoct_q.eq    <= yeq_d;
    yoct_q.quad  <= {zp_q, !xp_q};
    d_q          <= d_d;
    ay2_q        <= ay_q;
    yp2_q        <= yp_q;

    ynum2_q      <= ynum_q;
    yden2_q      <= yden_q;
    yoct2_q      <= yoct_q;
    pnum_q       <= plt_d ? ay2_q : d_q;
    pden_q       <= plt_d ? d_q : ay2_q;
    poct_q.lt    <= plt_d;
    poct_q.eq    <= peq_d;
    poct_q.quad  <= {(d_q != '0), !yp2_q};
  end

  assign valid_o   = vld_q[2];
  assign yaw_num_o = ynum2_q;
  assign yaw_den_o = yden2_q;
  assign yaw_oct_o = yoct2_q;
  assign pit_num_o = pnum_q;
  assign pit_den_o = pden_q;
  assign pit_oct_o = poct_q;

endmodule

`default_nettype wire

/* rtl/vtyp_div.sv */
// ----------------------------------------------------------------------------
// vtyp_div: pipelined restoring divider lane
// Computes floor(num*STEPS/den) for num below den, one quotient bit per
// stage, with the octant sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module vtyp_div #(
  parameter int unsigned M     = 25,
  parameter int unsigned STEPS = 128,
  parameter int unsigned QB    = 7
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wire  [M-1:0]         num_i,
  input  wire  [M-1:0]         den_i,
  input  vtyp_pkg::oct_t       oct_i,
  output logic                 valid_o,
  output logic [QB-1:0]        quo_o,
  output vtyp_pkg::oct_t       oct_o
);

  localparam int unsigned PW = M + QB;

  logic [PW-1:0] prod;
  assign prod = PW'(num_i) * PW'(STEPS);

  logic [QB:0]    vld_q;
  logic [M:0]     rem_q [QB+1];
  logic [QB-1:0]  low_q [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic [M-1:0]   den_q [QB+1];
  vtyp_pkg::oct_t oct_q [QB+1];

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  // load entry stage: high part of num*STEPS is the first partial remainder
  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, prod[PW-1:QB]};
    low_q[0] <= prod[QB-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    oct_q[0] <= oct_i;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [M+1:0] trial;
    logic         take;
    assign trial = {rem_q[k], low_q[k][QB-1]};
    assign take  = trial >= {2'b00, den_q[k]};

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? (M+1)'(trial - {2'b00, den_q[k]}) : trial[M:0];
      low_q[k+1] <= low_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][QB-2:0], take};
      den_q[k+1] <= den_q[k];
      oct_q[k+1] <= oct_q[k];
    end
  end

  assign valid_o = vld_q[QB];
  assign quo_o   = quo_q[QB];
  assign oct_o   = oct_q[QB];

endmodule

`default_nettype wire

/* rtl/vtyp_oct.sv */
// ----------------------------------------------------------------------------
// vtyp_oct: ROM lookup and octant/quadrant correction
// Reads the first-octant arctangent ROM for each angle, folds the octant
// and quadrant in, scales to 4096 per turn and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vtyp_oct #(
  parameter int unsigned STEPS = 128,
  parameter int unsigned QB    = 7
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wire  [QB-1:0]        yaw_quo_i,
  input  vtyp_pkg::oct_t       yaw_oct_i,
  input  wire  [QB-1:0]        pit_quo_i,
  input  vtyp_pkg::oct_t       pit_oct_i,
  output logic                 valid_o,
  output vtyp_pkg::res_t       res_o
);

  localparam int unsigned DEPTH = 1 << QB;

  // constant arctangent ROM
  logic [5:0] rom [DEPTH];
  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    if (g < STEPS) begin : g_used
      assign rom[g] = vtyp_pkg::rom_entry(longint'(g), longint'(STEPS));
    end else begin : g_pad
      assign rom[g] = '0;
    end
  end

  function automatic logic [vtyp_pkg::ANGLE_BITS-1:0] fold(input logic [5:0] r,
                                                           input vtyp_pkg::oct_t o);
    logic [7:0] a;
    a = o.eq ? vtyp_pkg::OCT_DIAG :
        o.lt ? {2'b00, r} : (vtyp_pkg::OCT_QTR - {2'b00, r});
    case (o.quad)
      vtyp_pkg::QUAD_PN: a = 8'h00 - a;
      vtyp_pkg::QUAD_NP: a = vtyp_pkg::OCT_HALF - a;
      vtyp_pkg::QUAD_PP: a = a + vtyp_pkg::OCT_HALF;
      default:           a = a;
    endcase
    return vtyp_pkg::ANGLE_BASE - {a, 4'h0};
  endfunction

  logic           vld_q;
  vtyp_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  // hold the corrected angles
  always_ff @(posedge clk_i) begin
    res_q.yaw_angle   <= fold(rom[yaw_quo_i], yaw_oct_i);
    res_q.pitch_angle <= fold(rom[pit_quo_i], pit_oct_i);
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* rtl/vector_to_yaw_pitch_top.sv */
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_top: direction vector to yaw and pitch angles
// Fully pipelined; one request per clock, one result per request.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start_i is high (busy_o stays low),
// and its result appears on res_o with valid_o high, in request order, after
// the request register, the preparation stages, the divider lanes and the
// output register. The divider lanes resolve one quotient bit per stage; the
// receiver cannot stall, so valid_o is a one-cycle strobe. Only the low
// COORD_BITS bits of each coordinate count.
`default_nettype none

module vector_to_yaw_pitch_top #(
  parameter int unsigned TABLE_STEPS = 128,
  parameter int unsigned COORD_BITS  = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  vtyp_pkg::req_t       req_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output vtyp_pkg::res_t       res_o
);

  localparam int unsigned QB  = $clog2(TABLE_STEPS);
  localparam int unsigned M   = COORD_BITS + 1;
  localparam int unsigned LAT = QB + 6;

  // request register
  logic           in_vld_q;
  vtyp_pkg::req_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  assign busy_o = 1'b0;

  logic           pr_vld;
  logic [M-1:0]   y_num, y_den, p_num, p_den;
  vtyp_pkg::oct_t y_oct, p_oct;

  vtyp_prep #(.W(COORD_BITS)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_vld_q),
    .req_i     (in_q),
    .valid_o   (pr_vld),
    .yaw_num_o (y_num),
    .yaw_den_o (y_den),
    .yaw_oct_o (y_oct),
    .pit_num_o (p_num),
    .pit_den_o (p_den),
    .pit_oct_o (p_oct)
  );

  logic           yd_vld, pd_vld;
  logic [QB-1:0]  y_quo, p_quo;
  vtyp_pkg::oct_t yd_oct, pd_oct;

  vtyp_div #(.M(M), .STEPS(TABLE_STEPS), .QB(QB)) u_div_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pr_vld),
    .num_i   (y_num),
    .den_i   (y_den),
    .oct_i   (y_oct),
    .valid_o (yd_vld),
    .quo_o   (y_quo),
    .oct_o   (yd_oct)
  );

  vtyp_div #(.M(M), .STEPS(TABLE_STEPS), .QB(QB)) u_div_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pr_vld),
    .num_i   (p_num),
    .den_i   (p_den),
    .oct_i   (p_oct),
    .valid_o (pd_vld),
    .quo_o   (p_quo),
    .oct_o   (pd_oct)
  );

  vtyp_oct #(.STEPS(TABLE_STEPS), .QB(QB)) u_oct (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (yd_vld & pd_vld),
    .yaw_quo_i (y_quo),
    .yaw_oct_i (yd_oct),
    .pit_quo_i (p_quo),
    .pit_oct_i (pd_oct),
    .valid_o   (valid_o),
    .res_o     (res_o)
  );

  // both divider lanes stay in step
  assert property (@(posedge clk_i) disable iff (!rst_ni) yd_vld == pd_vld)
    else $error("divider lanes out of step");

  // every request yields exactly one result after the pipeline latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, LAT) |-> (valid_o == $past(start_i && !busy_o, LAT)))
    else $error("result strobe does not match request latency");

  // a zero vector maps to the fixed code on both angles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, LAT) && $past(start_i && (req_i.vec_x[COORD_BITS-1:0] == '0)
      && (req_i.vec_y[COORD_BITS-1:0] == '0)
      && (req_i.vec_z[COORD_BITS-1:0] == '0), LAT))
    |-> (res_o.yaw_angle == 12'hA00 && res_o.pitch_angle == 12'hA00))
    else $error("zero vector result wrong");

endmodule

`default_nettype wire
